// ===== hw/rtl/smcsr_pkg.sv =====
// shared types and constants for the compressed sparse row matrix store
package smcsr_pkg;

  localparam int ROW_W    = 6;
  localparam int COL_W    = 6;
  localparam int VALUE_W  = 32;
  localparam int CFG_W    = 7;
  localparam int CFG_IDX_W = 2;
  localparam int STATUS_W = 2;

  localparam int MAX_ROWS_DEF    = 64;
  localparam int MAX_COLS_DEF    = 64;
  localparam int MAX_ENTRIES_DEF = 1024;
  localparam int DATA_WIDTH_DEF  = 32;

  localparam logic [CFG_W-1:0] NUM_ROWS_RST = 7'd64;
  localparam logic [CFG_W-1:0] NUM_COLS_RST = 7'd64;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_NUM_ROWS = 2'd0,
    REG_NUM_COLS = 2'd1
  } reg_idx_e;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_QUERY  = 1'b1
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE  = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

endpackage

// ===== hw/rtl/sparse_matrix_csr_store.sv =====
// compressed sparse row matrix store with insert and query sequencer
// out-of-range and full items: result in the cycle after the transfer; a query reads the
//   next row's pointer, then its own, and scans its entries up to the first match; an
//   insert moves each later entry one slot up, writes the new entry and adds one to each
//   later row pointer; one item at a time, busy_o drops with the result strobe; reset:
//   entry count clears and sizes return to 64 at once, then the clear state zeroes every
//   row pointer while busy_o is high; results cannot be stalled by the receiver
module sparse_matrix_csr_store
  import smcsr_pkg::*;
#(
  parameter int MAX_ROWS    = MAX_ROWS_DEF,
  parameter int MAX_COLS    = MAX_COLS_DEF,
  parameter int MAX_ENTRIES = MAX_ENTRIES_DEF,
  parameter int DATA_WIDTH  = DATA_WIDTH_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // config write port
  input  logic                       cfg_we_i,
  input  logic [CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [CFG_W-1:0]           cfg_wdata_i,
  // command side
  input  logic                       start_i,
  output logic                       busy_o,
  input  logic                       op_i,
  input  logic [ROW_W-1:0]           row_i,
  input  logic [COL_W-1:0]           col_i,
  input  logic signed [VALUE_W-1:0]  value_i,
  // result side
  output logic                       done_o,
  output logic [STATUS_W-1:0]        status_o,
  output logic signed [VALUE_W-1:0]  read_value_o
);

  // count holds 0..MAX_ENTRIES, address holds 0..MAX_ENTRIES-1
  localparam int CW    = $clog2(MAX_ENTRIES + 1);
  localparam int AW    = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int RPW   = $clog2(MAX_ROWS + 1);
  localparam int ENT_W = COL_W + DATA_WIDTH;

  localparam logic [RPW-1:0] LAST_PTR = RPW'(MAX_ROWS);
  localparam logic [CW-1:0]  FULL_CNT = CW'(MAX_ENTRIES);

  typedef enum logic [8:0] {
    S_CLEAR = 9'b000000001,
    S_IDLE  = 9'b000000010,
    S_PTR0  = 9'b000000100,
    S_PTR1  = 9'b000001000,
    S_SHIFT = 9'b000010000,
    S_DRAIN = 9'b000100000,
    S_PUT   = 9'b001000000,
    S_INC   = 9'b010000000,
    S_SCAN  = 9'b100000000
  } state_e;

  // config registers
  logic [CFG_W-1:0] num_rows_q, num_cols_q;

  // control state
  state_e           state_q, state_d;
  logic [RPW-1:0]   clr_q, clr_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic [CW-1:0]    pos_q, pos_d;     // insert slot, or end of row on query
  logic [AW-1:0]    ra_q, ra_d;       // shift read address, walks down
  logic [CW-1:0]    sa_q, sa_d;       // scan read address, walks up
  logic             wb_pend_q, wb_pend_d;
  logic [AW-1:0]    wb_addr_q, wb_addr_d;
  logic [RPW-1:0]   k_q, k_d;
  logic             chk_q, chk_d;
  logic             done_q, done_d;
  status_e          status_q, status_d;
  logic [VALUE_W-1:0] rdval_q, rdval_d;

  // item payload, no reset needed
  op_e                   op_q;
  logic [ROW_W-1:0]      row_q;
  logic [COL_W-1:0]      col_q;
  logic [DATA_WIDTH-1:0] val_q;

  // entry memory: {column, value}
  logic [ENT_W-1:0] ent_mem [MAX_ENTRIES];
  logic             ent_we, ent_re;
  logic [AW-1:0]    ent_waddr, ent_raddr;
  logic [ENT_W-1:0] ent_wdata, ent_rdata_q;

  // row pointer memory
  logic [CW-1:0]    ptr_mem [MAX_ROWS+1];
  logic             ptr_we, ptr_re;
  logic [RPW-1:0]   ptr_waddr, ptr_raddr;
  logic [CW-1:0]    ptr_wdata, ptr_rdata_q;

  logic             row_ok, col_ok, accept;
  logic [CW-1:0]    hi_clamp;
  logic [COL_W-1:0] rd_col;
  logic             col_hit;

  always_ff @(posedge clk_i) begin
    if (ent_we) begin
      ent_mem[ent_waddr] <= ent_wdata;
    end
    if (ent_re) begin
      ent_rdata_q <= ent_mem[ent_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ptr_we) begin
      ptr_mem[ptr_waddr] <= ptr_wdata;
    end
    if (ptr_re) begin
      ptr_rdata_q <= ptr_mem[ptr_raddr];
    end
  end

  // range check against configured size, capped by the build limits
  assign row_ok = ({1'b0, row_i} < num_rows_q) && (32'(row_i) < MAX_ROWS);
  assign col_ok = ({1'b0, col_i} < num_cols_q) && (32'(col_i) < MAX_COLS);
  assign accept = start_i && (state_q == S_IDLE);

  // end of row never beyond the stored count
  assign hi_clamp = (ptr_rdata_q > cnt_q) ? cnt_q : ptr_rdata_q;
  assign rd_col   = ent_rdata_q[ENT_W-1 -: COL_W];
  assign col_hit  = chk_q && (rd_col == col_q);

  always_comb begin
    state_d   = state_q;
    clr_d     = clr_q;
    cnt_d     = cnt_q;
    pos_d     = pos_q;
    ra_d      = ra_q;
    sa_d      = sa_q;
    wb_pend_d = 1'b0;
    wb_addr_d = wb_addr_q;
    k_d       = k_q;
    chk_d     = 1'b0;
    done_d    = 1'b0;
    status_d  = status_q;
    rdval_d   = rdval_q;

    ent_re    = 1'b0;
    ent_raddr = ra_q;
    ptr_re    = 1'b0;
    ptr_raddr = k_q;
    ptr_we    = 1'b0;
    ptr_waddr = k_q;
    ptr_wdata = ptr_rdata_q + CW'(1);

    // shifted entry lands one slot up, in the cycle after its read
    ent_we    = wb_pend_q;
    ent_waddr = wb_addr_q;
    ent_wdata = ent_rdata_q;

    unique case (state_q)
      S_CLEAR: begin
        ptr_we    = 1'b1;
        ptr_waddr = clr_q;
        ptr_wdata = '0;
        if (clr_q == LAST_PTR) begin
          state_d = S_IDLE;
        end else begin
          clr_d = clr_q + RPW'(1);
        end
      end

      S_IDLE: begin
        if (start_i) begin
          if (!(row_ok && col_ok)) begin
            done_d   = 1'b1;
            status_d = ST_RANGE;
            rdval_d  = '0;
          end else if ((op_e'(op_i) == OP_INSERT) && (cnt_q == FULL_CNT)) begin
            done_d   = 1'b1;
            status_d = ST_FULL;
            rdval_d  = '0;
          end else begin
            // fetch start of the next row
            ptr_re    = 1'b1;
            ptr_raddr = RPW'({1'b0, row_i} + 7'd1);
            state_d   = S_PTR0;
          end
        end
      end

      S_PTR0: begin
        pos_d = hi_clamp;
        if (op_q == OP_INSERT) begin
          if (cnt_q > hi_clamp) begin
            ra_d    = AW'(cnt_q - CW'(1));
            state_d = S_SHIFT;
          end else begin
            state_d = S_PUT;
          end
        end else begin
          ptr_re    = 1'b1;
          ptr_raddr = RPW'(row_q);
          state_d   = S_PTR1;
        end
      end

      S_PTR1: begin
        if (ptr_rdata_q >= pos_q) begin
          // empty row
          done_d   = 1'b1;
          status_d = ST_DONE;
          rdval_d  = '0;
          state_d  = S_IDLE;
        end else begin
          sa_d    = ptr_rdata_q;
          state_d = S_SCAN;
        end
      end

      S_SHIFT: begin
        ent_re    = 1'b1;
        ent_raddr = ra_q;
        wb_pend_d = 1'b1;
        wb_addr_d = ra_q + AW'(1);
        if (CW'(ra_q) == pos_q) begin
          state_d = S_DRAIN;
        end else begin
          ra_d = ra_q - AW'(1);
        end
      end

      S_DRAIN: begin
        state_d = S_PUT;
      end

      S_PUT: begin
        ent_we    = 1'b1;
        ent_waddr = pos_q[AW-1:0];
        ent_wdata = {col_q, val_q};
        ptr_re    = 1'b1;
        ptr_raddr = RPW'({1'b0, row_q} + 7'd1);
        k_d       = RPW'({1'b0, row_q} + 7'd1);
        state_d   = S_INC;
      end

      S_INC: begin
        // read-modify-write walk over the later row pointers
        ptr_we    = 1'b1;
        ptr_waddr = k_q;
        if (k_q == LAST_PTR) begin
          cnt_d    = cnt_q + CW'(1);
          done_d   = 1'b1;
          status_d = ST_DONE;
          rdval_d  = '0;
          state_d  = S_IDLE;
        end else begin
          ptr_re    = 1'b1;
          ptr_raddr = k_q + RPW'(1);
          k_d       = k_q + RPW'(1);
        end
      end

      S_SCAN: begin
        if (col_hit) begin
          done_d   = 1'b1;
          status_d = ST_DONE;
          rdval_d  = VALUE_W'(ent_rdata_q[DATA_WIDTH-1:0]);
          state_d  = S_IDLE;
        end else if (sa_q < pos_q) begin
          ent_re    = 1'b1;
          ent_raddr = sa_q[AW-1:0];
          chk_d     = 1'b1;
          sa_d      = sa_q + CW'(1);
        end else begin
          // last entry checked, no match
          done_d   = 1'b1;
          status_d = ST_DONE;
          rdval_d  = '0;
          state_d  = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_CLEAR;
      clr_q      <= '0;
      cnt_q      <= '0;
      pos_q      <= '0;
      ra_q       <= '0;
      sa_q       <= '0;
      wb_pend_q  <= 1'b0;
      wb_addr_q  <= '0;
      k_q        <= '0;
      chk_q      <= 1'b0;
      done_q     <= 1'b0;
      status_q   <= ST_DONE;
      rdval_q    <= '0;
      num_rows_q <= NUM_ROWS_RST;
      num_cols_q <= NUM_COLS_RST;
    end else begin
      state_q   <= state_d;
      clr_q     <= clr_d;
      cnt_q     <= cnt_d;
      pos_q     <= pos_d;
      ra_q      <= ra_d;
      sa_q      <= sa_d;
      wb_pend_q <= wb_pend_d;
      wb_addr_q <= wb_addr_d;
      k_q       <= k_d;
      chk_q     <= chk_d;
      done_q    <= done_d;
      status_q  <= status_d;
      rdval_q   <= rdval_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          REG_NUM_ROWS: num_rows_q <= cfg_wdata_i;
          REG_NUM_COLS: num_cols_q <= cfg_wdata_i;
          default: ;
        endcase
      end
    end
  end

  // capture the item on transfer
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q  <= op_e'(op_i);
      row_q <= row_i;
      col_q <= col_i;
      val_q <= DATA_WIDTH'($unsigned(value_i));
    end
  end

  assign busy_o       = (state_q != S_IDLE);
  assign done_o       = done_q;
  assign status_o     = status_q;
  assign read_value_o = $signed(rdval_q);

  // a result always comes with the sequencer back at rest
  a_done_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy_o)
    else $error("result strobe while sequencer busy");

  a_cnt_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= FULL_CNT)
    else $error("entry count beyond capacity");

  a_full_cnt : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (status_o == ST_FULL)) |-> (cnt_q == FULL_CNT))
    else $error("store full reported below capacity");

  a_wb_phase : assert property (@(posedge clk_i) disable iff (!rst_ni)
    wb_pend_q |-> ((state_q == S_SHIFT) || (state_q == S_DRAIN)))
    else $error("entry shift write outside shift phase");

  a_cnt_step : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q != $past(cnt_q)) |-> (done_o && (status_o == ST_DONE)))
    else $error("entry count changed without a completed insert");

endmodule

// ===== bench/sparse_matrix_csr_store_tb.sv =====
// self-checking testbench for the compressed sparse row matrix store
module sparse_matrix_csr_store_tb;
  import smcsr_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_ROWS    = MAX_ROWS_DEF;
  localparam int MAX_COLS    = MAX_COLS_DEF;
  localparam int MAX_ENTRIES = MAX_ENTRIES_DEF;
  localparam int DATA_WIDTH  = DATA_WIDTH_DEF;

  // the register port has room for two indexes that select nothing
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

  localparam logic signed [VALUE_W-1:0] VAL_MAX = 32'h7fff_ffff;
  localparam logic signed [VALUE_W-1:0] VAL_MIN = 32'h8000_0000;

  // worst insert: every stored entry shifts and every row pointer moves
  localparam int SETTLE_CYCLES = MAX_ENTRIES + MAX_ROWS + 100;

  typedef struct packed {
    status_e                    status;
    logic signed [VALUE_W-1:0]  read_value;
  } csr_result_t;

  typedef enum logic {
    STEP_ITEM,
    STEP_WRITE
  } step_kind_e;

  // one row of the directed table: an item or a register write
  typedef struct packed {
    step_kind_e                 kind;
    op_e                        op;
    logic [ROW_W-1:0]           row;
    logic [COL_W-1:0]           col;
    logic signed [VALUE_W-1:0]  value;
    logic [CFG_IDX_W-1:0]       idx;
    logic [CFG_W-1:0]           data;
    logic                       typed;
    csr_result_t                want;
  } plan_step_t;

  logic                       clk_i;
  logic                       rst_ni      = 1'b0;
  logic                       cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0]       cfg_idx_i   = '0;
  logic [CFG_W-1:0]           cfg_wdata_i = '0;
  logic                       start_i     = 1'b0;
  logic                       busy_o;
  logic                       op_i        = 1'b0;
  logic [ROW_W-1:0]           row_i       = '0;
  logic [COL_W-1:0]           col_i       = '0;
  logic signed [VALUE_W-1:0]  value_i     = '0;
  logic                       done_o;
  logic [STATUS_W-1:0]        status_o;
  logic signed [VALUE_W-1:0]  read_value_o;

  sparse_matrix_csr_store #(
    .MAX_ROWS    (MAX_ROWS),
    .MAX_COLS    (MAX_COLS),
    .MAX_ENTRIES (MAX_ENTRIES),
    .DATA_WIDTH  (DATA_WIDTH)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .start_i      (start_i),
    .busy_o       (busy_o),
    .op_i         (op_i),
    .row_i        (row_i),
    .col_i        (col_i),
    .value_i      (value_i),
    .done_o       (done_o),
    .status_o     (status_o),
    .read_value_o (read_value_o)
  );

  // ---------------------------------------------------------------------------
  // shadow copy of the matrix: values and columns in row order, row start
  // pointers over all MAX_ROWS rows, the entry total and the size registers
  // ---------------------------------------------------------------------------
  logic signed [VALUE_W-1:0]  slot_value [MAX_ENTRIES];
  logic [COL_W-1:0]           slot_col   [MAX_ENTRIES];
  int                         row_first  [MAX_ROWS+1];
  int                         entry_total;
  logic [CFG_W-1:0]           rows_cfg;
  logic [CFG_W-1:0]           cols_cfg;

  csr_result_t                result_q [$];   // results still owed by the block
  logic [ROW_W+COL_W-1:0]     placed_q [$];   // positions that got an entry

  int fail_cnt;
  int idle_pct;
  int n_items, n_inserts, n_queries, n_range, n_full, n_nonzero;

  // ---------------------------------------------------------------------------
  // matrix predictor: applies one item to the shadow copy, returns the result
  // ---------------------------------------------------------------------------
  function automatic csr_result_t csr_apply(op_e op, logic [ROW_W-1:0] row,
      logic [COL_W-1:0] col, logic signed [VALUE_W-1:0] value);
    csr_result_t res;
    int          r, c, lim_r, lim_c, pos, hi, k;
    bit          found;
    res.status     = ST_DONE;
    res.read_value = '0;
    r     = int'(row);
    c     = int'(col);
    // sizes above the store's dimensions clamp, zero rejects every index
    lim_r = (int'(rows_cfg) < MAX_ROWS) ? int'(rows_cfg) : MAX_ROWS;
    lim_c = (int'(cols_cfg) < MAX_COLS) ? int'(cols_cfg) : MAX_COLS;
    if (r >= lim_r || c >= lim_c) begin
      res.status = ST_RANGE;
    end else if (op == OP_INSERT) begin
      if (entry_total >= MAX_ENTRIES) begin
        res.status = ST_FULL;
      end else begin
        // new entry goes behind the last one of its row, later slots move up
        pos = (row_first[r+1] > entry_total) ? entry_total : row_first[r+1];
        for (k = entry_total; k > pos; k--) begin
          slot_value[k] = slot_value[k-1];
          slot_col[k]   = slot_col[k-1];
        end
        slot_value[pos] = value;
        slot_col[pos]   = col;
        for (k = r + 1; k <= MAX_ROWS; k++) begin
          row_first[k]++;
        end
        entry_total++;
      end
    end else begin
      // first match in storage order wins, so the oldest duplicate answers
      hi    = (row_first[r+1] > entry_total) ? entry_total : row_first[r+1];
      found = 1'b0;
      for (k = row_first[r]; k < hi && !found; k++) begin
        if (slot_col[k] == col) begin
          res.read_value = slot_value[k];
          found          = 1'b1;
        end
      end
    end
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // directed table rows
  // ---------------------------------------------------------------------------
  function automatic plan_step_t step_item(op_e op, int row, int col,
      logic signed [VALUE_W-1:0] value);
    plan_step_t s;
    s       = '0;
    s.kind  = STEP_ITEM;
    s.op    = op;
    s.row   = ROW_W'(row);
    s.col   = COL_W'(col);
    s.value = value;
    return s;
  endfunction

  function automatic plan_step_t step_check(op_e op, int row, int col,
      logic signed [VALUE_W-1:0] value, status_e status,
      logic signed [VALUE_W-1:0] read_value);
    plan_step_t s;
    s                 = step_item(op, row, col, value);
    s.typed           = 1'b1;
    s.want.status     = status;
    s.want.read_value = read_value;
    return s;
  endfunction

  function automatic plan_step_t step_write(logic [CFG_IDX_W-1:0] idx,
      logic [CFG_W-1:0] data);
    plan_step_t s;
    s      = '0;
    s.kind = STEP_WRITE;
    s.idx  = idx;
    s.data = data;
    return s;
  endfunction

  task automatic note_failure(string msg);
    fail_cnt++;
    if (fail_cnt <= 10) begin
      $display("[%0t] mismatch: %s", $realtime, msg);
    end
  endtask

  // ---------------------------------------------------------------------------
  // clock and timeout
  // ---------------------------------------------------------------------------
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // far beyond the slowest legal run: every insert shifting the full store
  initial begin
    #100ms;
    $display("sparse_matrix_csr_store_tb NOT OK");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // result checker: a strobed result is taken mid-cycle, the outputs are
  // stable there, and compared against the oldest owed result
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin
    csr_result_t want;
    if (rst_ni && done_o) begin
      if (result_q.size() == 0) begin
        note_failure($sformatf("result with nothing owed: status %0d value %0h",
                               status_o, read_value_o));
      end else begin
        want = result_q.pop_front();
        if (status_o !== want.status || read_value_o !== want.read_value) begin
          note_failure($sformatf("status %0d value %0h, wanted status %0d value %0h",
                                 status_o, read_value_o, want.status, want.read_value));
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // command side; every task is entered and left just after a rising edge
  // ---------------------------------------------------------------------------

  // present one item and hold it until the transfer, then book its result
  task automatic drive_item(op_e op, logic [ROW_W-1:0] row, logic [COL_W-1:0] col,
      logic signed [VALUE_W-1:0] value, bit typed, csr_result_t typed_want);
    csr_result_t pred;
    bit          taken;
    start_i <= 1'b1;
    op_i    <= op;
    row_i   <= row;
    col_i   <= col;
    value_i <= value;
    // busy is settled mid-cycle and decides the transfer at the next edge
    do begin
      @(negedge clk_i);
      taken = !busy_o;
      @(posedge clk_i);
    end while (!taken);
    pred = csr_apply(op, row, col, value);
    result_q.push_back(typed ? typed_want : pred);
    n_items++;
    case (pred.status)
      ST_RANGE: n_range++;
      ST_FULL:  n_full++;
      default: begin
        if (op == OP_INSERT) begin
          n_inserts++;
          placed_q.push_back({row, col});
        end else begin
          n_queries++;
          if (pred.read_value != 0) n_nonzero++;
        end
      end
    endcase
  endtask

  // stop sending and wait until every owed result is in and the block is free
  task automatic drain();
    start_i <= 1'b0;
    do @(negedge clk_i); while (result_q.size() != 0 || busy_o);
    @(posedge clk_i);
  endtask

  // register write; the leading edge keeps raise and lower of the enable
  // apart when writes follow each other
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    if (idx == REG_NUM_ROWS) rows_cfg = data;
    else if (idx == REG_NUM_COLS) cols_cfg = data;
  endtask

  task automatic idle_gap();
    while (int'($urandom_range(99)) < idle_pct) begin
      start_i <= 1'b0;
      @(posedge clk_i);
    end
  endtask

  // one random item: mostly in range, queries mostly aimed at stored
  // positions, a share of raw noise over the whole index space
  task automatic random_item(int ins_pct);
    int                        lim_r, lim_c;
    logic [ROW_W+COL_W-1:0]    spot;
    op_e                       op;
    logic [ROW_W-1:0]          r;
    logic [COL_W-1:0]          c;
    logic signed [VALUE_W-1:0] v;
    if ($urandom_range(99) < 2) drain();
    else idle_gap();
    lim_r = (int'(rows_cfg) < MAX_ROWS) ? int'(rows_cfg) : MAX_ROWS;
    lim_c = (int'(cols_cfg) < MAX_COLS) ? int'(cols_cfg) : MAX_COLS;
    op    = (int'($urandom_range(99)) < ins_pct) ? OP_INSERT : OP_QUERY;
    if ($urandom_range(99) < 8 || lim_r == 0 || lim_c == 0) begin
      r = ROW_W'($urandom_range(MAX_ROWS - 1));
      c = COL_W'($urandom_range(MAX_COLS - 1));
    end else if (op == OP_QUERY && placed_q.size() != 0 && $urandom_range(99) < 70) begin
      spot = placed_q[$urandom_range(placed_q.size() - 1)];
      r    = spot[ROW_W+COL_W-1:COL_W];
      c    = spot[COL_W-1:0];
    end else begin
      r = ROW_W'($urandom_range(lim_r - 1));
      c = COL_W'($urandom_range(lim_c - 1));
    end
    v = $urandom;
    drive_item(op, r, c, v, 1'b0, '0);
  endtask

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------
  initial begin
    plan_step_t        plan [$];
    logic [CFG_W-1:0]  size_rows [6];
    logic [CFG_W-1:0]  size_cols [6];
    int                fill_items;

    // shadow copy matches the block after reset
    foreach (row_first[k]) row_first[k] = 0;
    entry_total = 0;
    rows_cfg    = NUM_ROWS_RST;
    cols_cfg    = NUM_COLS_RST;
    fail_cnt    = 0;
    idle_pct    = 19;
    n_items     = 0;
    n_inserts   = 0;
    n_queries   = 0;
    n_range     = 0;
    n_full      = 0;
    n_nonzero   = 0;

    // directed part: extremes, duplicates, row shifts, sizes at their limits,
    // a zero size, sizes beyond the store and writes to unused indexes
    plan = '{
      step_check(OP_QUERY,   0,  0, VAL_MAX, ST_DONE, '0),
      step_check(OP_QUERY,  63, 63, VAL_MIN, ST_DONE, '0),
      step_check(OP_INSERT,  0,  0, VAL_MAX, ST_DONE, '0),
      step_check(OP_INSERT, 63, 63, VAL_MIN, ST_DONE, '0),
      step_check(OP_QUERY,   0,  0, '0,      ST_DONE, VAL_MAX),
      step_check(OP_QUERY,  63, 63, '0,      ST_DONE, VAL_MIN),
      step_item (OP_INSERT,  5, 10, 32'hffff_ffff),
      step_item (OP_INSERT,  5, 10, 32'h0000_0001),   // duplicate position
      step_item (OP_QUERY,   5, 10, '0),
      step_item (OP_INSERT,  5,  3, 32'h5555_aaaa),
      step_item (OP_QUERY,   5,  3, '0),
      step_item (OP_QUERY,   5,  4, '0),              // absent column
      step_item (OP_INSERT,  4, 10, 32'h0000_0042),   // shifts row 5 up
      step_item (OP_QUERY,   5, 10, '0),
      step_write(REG_NUM_ROWS, 7'd1),
      step_write(REG_NUM_COLS, 7'd1),
      step_check(OP_QUERY,   0,  0, '0,      ST_DONE,  VAL_MAX),
      step_check(OP_INSERT,  1,  0, VAL_MAX, ST_RANGE, '0),
      step_check(OP_INSERT,  0,  1, VAL_MIN, ST_RANGE, '0),
      step_check(OP_QUERY,  63, 63, '0,      ST_RANGE, '0),
      step_write(REG_NUM_ROWS, 7'd0),
      step_check(OP_QUERY,   0,  0, '0,      ST_RANGE, '0),
      step_write(REG_NUM_ROWS, 7'h7f),
      step_write(REG_NUM_COLS, 7'h7f),
      step_write(REG_SPARE_2,  7'd0),
      step_write(REG_SPARE_3,  7'h7f),
      step_check(OP_QUERY,  63, 63, '0,      ST_DONE,  VAL_MIN),
      step_item (OP_INSERT, 32, 31, 32'haaaa_5555),
      step_item (OP_QUERY,  32, 31, '0),
      step_item (OP_INSERT,  0, 63, '0),
      step_item (OP_QUERY,   0, 63, '0)
    };

    // sizes for the mixed phases; the last two are drawn at random
    size_rows = '{7'd4, 7'd1,  7'd64, 7'd127, 7'd20, 7'd9};
    size_cols = '{7'd4, 7'd64, 7'd1,  7'd127, 7'd33, 7'd64};

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    // the row pointer clearing pass keeps busy high for a while
    drain();

    foreach (plan[i]) begin
      if (plan[i].kind == STEP_WRITE) begin
        drain();
        write_reg(plan[i].idx, plan[i].data);
      end else begin
        idle_gap();
        drive_item(plan[i].op, plan[i].row, plan[i].col, plan[i].value,
                   plan[i].typed, plan[i].want);
      end
    end

    // mixed phases, a size setting each, heavy on duplicates at small sizes
    for (int ph = 0; ph < 6; ph++) begin
      drain();
      if (ph >= 4) begin
        size_rows[ph] = CFG_W'($urandom_range(1, 127));
        size_cols[ph] = CFG_W'($urandom_range(1, 127));
      end
      write_reg(REG_NUM_ROWS, size_rows[ph]);
      write_reg(REG_NUM_COLS, size_cols[ph]);
      repeat (50) random_item(60);
    end

    // fill the store at full size; the first stretch runs back to back
    drain();
    write_reg(REG_NUM_ROWS, 7'd64);
    write_reg(REG_NUM_COLS, 7'd64);
    fill_items = 0;
    while (entry_total < MAX_ENTRIES) begin
      idle_pct = (fill_items < 250) ? 0 : 19;
      random_item(90);
      fill_items++;
    end

    // store full: inserts bounce, queries still find their entries
    idle_pct = 19;
    repeat (60) random_item(50);
    drain();
    write_reg(REG_NUM_ROWS, 7'd8);
    write_reg(REG_NUM_COLS, 7'd8);
    repeat (20) random_item(50);

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    $display("covered %0d transfers: %0d stored inserts, %0d in-range queries (%0d nonzero)",
             n_items, n_inserts, n_queries, n_nonzero);
    $display("  %0d out-of-range items, %0d store-full rejects, %0d mismatches",
             n_range, n_full, fail_cnt);
    if (fail_cnt == 0 && result_q.size() == 0) begin
      $display("sparse_matrix_csr_store_tb OK");
    end else begin
      $display("sparse_matrix_csr_store_tb NOT OK");
    end
    $finish;
  end

endmodule
